// File: rtl/smte_pkg.sv
// ============================================================================
// smte_pkg: shared types and constants of the sparse matrix triplet engine
// Holds the channel payload structs, opcodes, status codes, the controller
// state type and the command/status bundles between controller and datapath.
// ============================================================================
`default_nettype none

package smte_pkg;

    localparam int MAX_NNZ_DEF = 32;
    localparam int MAX_DIM_DEF = 256;

    localparam int DIM_W  = 9;
    localparam int IDX_W  = 8;
    localparam int VAL_W  = 32;
    localparam int CFG_IW = 2;

    typedef enum logic [2:0] {
        OP_LOAD_A    = 3'd0,
        OP_LOAD_B    = 3'd1,
        OP_CLEAR     = 3'd2,
        OP_ADD       = 3'd3,
        OP_SUB       = 3'd4,
        OP_MUL       = 3'd5,
        OP_DIV       = 3'd6,
        OP_TRANSPOSE = 3'd7
    } t_opcode;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_REJECT   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_MISMATCH = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;

    localparam logic [CFG_IW-1:0] REG_A_ROWS = 2'd0;
    localparam logic [CFG_IW-1:0] REG_A_COLS = 2'd1;
    localparam logic [CFG_IW-1:0] REG_B_ROWS = 2'd2;
    localparam logic [CFG_IW-1:0] REG_B_COLS = 2'd3;

    typedef struct packed {
        logic [2:0]              opcode;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [VAL_W-1:0] entry_value;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [VAL_W-1:0] out_value;
        logic                    entry_valid;
        logic [2:0]              status;
        logic                    last;
    } t_out;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] val;
    } t_trip;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOAD,
        S_CLEAR,
        S_MISMATCH,
        S_A_RD,
        S_A_GOT,
        S_A_APP,
        S_B_RD,
        S_B_GOT,
        S_MB_RD,
        S_MB_GOT,
        S_DV_BRD,
        S_DV_BGOT,
        S_DV_WAIT,
        S_ACC_START,
        S_ACC_RD,
        S_ACC_GOT,
        S_ACC_FIN,
        S_EMIT_INIT,
        S_EMIT_EMPTY,
        S_EMIT_RD,
        S_EMIT_GOT
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_LOAD,
        DP_CLEAR,
        DP_MISMATCH,
        DP_INIT,
        DP_A_LATCH,
        DP_A_APPEND,
        DP_I_NEXT,
        DP_J_NEXT,
        DP_DIV_START,
        DP_DIV_APPEND,
        DP_MUL_KEY,
        DP_B_KEY,
        DP_ACC_INIT,
        DP_ACC_STEP,
        DP_ACC_FIN,
        DP_EMIT_INIT,
        DP_EMIT_EMPTY,
        DP_EMIT_ITEM
    } t_dp_op;

    typedef struct packed {
        t_opcode op;
        logic    dim_ok;
        logic    i_end;
        logic    j_end;
        logic    k_end;
        logic    r_empty;
        logic    emit_last;
        logic    out_free;
        logic    div_busy;
        logic    b_match;
        logic    mul_match;
        logic    acc_match;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/smte_div.sv
// ============================================================================
// smte_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, quotient
// truncated toward zero with 32-bit wraparound.
// ============================================================================
`default_nettype none

module smte_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [smte_pkg::VAL_W-1:0] i_dividend,
    input  wire logic [smte_pkg::VAL_W-1:0] i_divisor,
    output logic                          o_busy,
    output logic [smte_pkg::VAL_W-1:0]    o_quot
);
    import smte_pkg::*;

    localparam int CNT_W = $clog2(VAL_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [VAL_W:0]   r_rem;
    logic [VAL_W-1:0] r_quo;
    logic [VAL_W-1:0] r_dsr;
    logic             r_neg;

    logic [VAL_W:0]   n_shift;
    logic             n_ge;

    always_comb begin
        n_shift = {r_rem[VAL_W-1:0], r_quo[VAL_W-1]};
        n_ge    = n_shift >= {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(VAL_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[VAL_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_dsr <= i_divisor[VAL_W-1] ? (~i_divisor + 1'b1) : i_divisor;
            r_neg <= i_dividend[VAL_W-1] ^ i_divisor[VAL_W-1];
        end else if (r_busy) begin
            r_rem <= n_ge ? (n_shift - {1'b0, r_dsr}) : n_shift;
            r_quo <= {r_quo[VAL_W-2:0], n_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

`default_nettype wire

// File: rtl/smte_dp.sv
// ============================================================================
// smte_dp: datapath of the sparse matrix triplet engine
// Triplet stores for A, B and the result list, index counters, the
// multiplier, the divider, configuration registers and the output register.
// ============================================================================
`default_nettype none

module smte_dp #(
    parameter int MAX_NNZ = smte_pkg::MAX_NNZ_DEF,
    parameter int MAX_DIM = smte_pkg::MAX_DIM_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire smte_pkg::t_dp_op            i_cmd,
    output smte_pkg::t_dp_stat               o_stat,
    input  wire smte_pkg::t_in               i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output smte_pkg::t_out                   o_out_data,
    input  wire logic                        i_cfg_valid,
    input  wire logic [smte_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [smte_pkg::DIM_W-1:0]  i_cfg_data
);
    import smte_pkg::*;

    localparam int CW = $clog2(MAX_NNZ + 1);
    localparam int AW = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;

    t_trip a_mem [MAX_NNZ];
    t_trip b_mem [MAX_NNZ];
    t_trip r_mem [MAX_NNZ];

    logic [DIM_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [CW-1:0]    r_a_cnt, r_b_cnt, r_r_cnt;
    logic [CW-1:0]    r_i, r_j, r_k, r_w;
    logic             r_ovf, r_found;
    t_in              r_in;
    t_trip            r_a, r_a_q, r_b_q, r_r_q;
    logic [IDX_W-1:0] r_key_row, r_key_col;
    logic [VAL_W-1:0] r_delta, r_cur;
    logic             r_out_valid;
    t_out             r_out;

    logic [CW-1:0]    n_r_cnt;
    logic             n_ovf;
    logic             app_en;
    logic [CW-1:0]    app_base;
    t_trip            app_trip;
    logic             rw_en;
    logic [CW-1:0]    rw_addr;
    t_trip            rw_data;
    logic             out_free;
    logic             div_busy;
    logic [VAL_W-1:0] div_quot;
    logic [DIM_W-1:0] cap_rows, cap_cols;
    logic [DIM_W-1:0] sel_rows, sel_cols;
    logic [2:0]       load_st;
    logic             is_a;

    smte_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd == DP_DIV_START),
        .i_dividend (r_a.val),
        .i_divisor  (r_b_q.val),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    // Load checks: index bounds first, then zero value, then capacity.
    always_comb begin
        is_a     = (t_opcode'(r_in.opcode) == OP_LOAD_A);
        sel_rows = is_a ? r_a_rows : r_b_rows;
        sel_cols = is_a ? r_a_cols : r_b_cols;
        cap_rows = (sel_rows > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : sel_rows;
        cap_cols = (sel_cols > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : sel_cols;
        if ({1'b0, r_in.row_index} >= cap_rows || {1'b0, r_in.col_index} >= cap_cols) begin
            load_st = ST_REJECT;
        end else if (r_in.entry_value == '0) begin
            load_st = ST_ZERO;
        end else if ((is_a ? r_a_cnt : r_b_cnt) >= CW'(MAX_NNZ)) begin
            load_st = ST_FULL;
        end else begin
            load_st = ST_OK;
        end
    end

    // Append to the result list; a zero value is dropped, a full list sets overflow.
    always_comb begin
        app_en   = 1'b0;
        app_base = r_r_cnt;
        app_trip = '0;
        case (i_cmd)
            DP_A_APPEND: begin
                app_en = 1'b1;
                if (t_opcode'(r_in.opcode) == OP_TRANSPOSE) begin
                    app_trip = '{row: r_a.col, col: r_a.row, val: r_a.val};
                end else begin
                    app_trip = r_a;
                end
            end
            DP_DIV_APPEND: begin
                app_en   = 1'b1;
                app_trip = '{row: r_a.row, col: r_a.col, val: div_quot};
            end
            DP_ACC_FIN: begin
                app_en   = 1'b1;
                app_base = r_w;
                app_trip = '{row: r_key_row, col: r_key_col, val: r_cur + r_delta};
            end
            default: begin
                app_en = 1'b0;
            end
        endcase

        n_r_cnt = r_r_cnt;
        n_ovf   = r_ovf;
        rw_en   = 1'b0;
        rw_addr = r_w;
        rw_data = r_r_q;
        if (app_en) begin
            n_r_cnt = app_base;
            rw_addr = app_base;
            rw_data = app_trip;
            if (app_trip.val != '0) begin
                if (app_base >= CW'(MAX_NNZ)) begin
                    n_ovf = 1'b1;
                end else begin
                    rw_en   = 1'b1;
                    n_r_cnt = app_base + 1'b1;
                end
            end
        end else if (i_cmd == DP_ACC_STEP && !o_stat.acc_match) begin
            rw_en = 1'b1;
        end
        if (i_cmd == DP_CLEAR || i_cmd == DP_INIT) begin
            n_r_cnt = '0;
            n_ovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_q <= a_mem[r_i[AW-1:0]];
        r_b_q <= b_mem[r_j[AW-1:0]];
        r_r_q <= r_mem[r_k[AW-1:0]];
        if (i_cmd == DP_LOAD && load_st == ST_OK) begin
            if (is_a) begin
                a_mem[r_a_cnt[AW-1:0]] <= '{row: r_in.row_index, col: r_in.col_index,
                                            val: r_in.entry_value};
            end else begin
                b_mem[r_b_cnt[AW-1:0]] <= '{row: r_in.row_index, col: r_in.col_index,
                                            val: r_in.entry_value};
            end
        end
        if (rw_en) begin
            r_mem[rw_addr[AW-1:0]] <= rw_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows    <= '0;
            r_a_cols    <= '0;
            r_b_rows    <= '0;
            r_b_cols    <= '0;
            r_a_cnt     <= '0;
            r_b_cnt     <= '0;
            r_r_cnt     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_A_ROWS: r_a_rows <= i_cfg_data;
                    REG_A_COLS: r_a_cols <= i_cfg_data;
                    REG_B_ROWS: r_b_rows <= i_cfg_data;
                    REG_B_COLS: r_b_cols <= i_cfg_data;
                    default:    r_a_rows <= r_a_rows;
                endcase
            end
            r_r_cnt <= n_r_cnt;
            r_ovf   <= n_ovf;
            case (i_cmd)
                DP_LOAD: begin
                    if (load_st == ST_OK) begin
                        if (is_a) begin
                            r_a_cnt <= r_a_cnt + 1'b1;
                        end else begin
                            r_b_cnt <= r_b_cnt + 1'b1;
                        end
                    end
                    r_out_valid <= 1'b1;
                end
                DP_CLEAR: begin
                    r_a_cnt     <= '0;
                    r_b_cnt     <= '0;
                    r_out_valid <= 1'b1;
                end
                DP_MISMATCH, DP_EMIT_EMPTY, DP_EMIT_ITEM: begin
                    r_out_valid <= 1'b1;
                end
                default: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            DP_ACCEPT: begin
                r_in <= i_in_data;
            end
            DP_LOAD: begin
                r_out <= '{out_row: '0, out_col: '0, out_value: '0, entry_valid: 1'b0,
                           status: load_st, last: 1'b1};
            end
            DP_CLEAR: begin
                r_out <= '{out_row: '0, out_col: '0, out_value: '0, entry_valid: 1'b0,
                           status: ST_OK, last: 1'b1};
            end
            DP_MISMATCH: begin
                r_out <= '{out_row: '0, out_col: '0, out_value: '0, entry_valid: 1'b0,
                           status: ST_MISMATCH, last: 1'b1};
            end
            DP_INIT: begin
                r_i <= '0;
                r_j <= '0;
            end
            DP_A_LATCH: begin
                r_a <= r_a_q;
                r_j <= '0;
            end
            DP_A_APPEND, DP_I_NEXT, DP_DIV_APPEND: begin
                r_i <= r_i + 1'b1;
            end
            DP_J_NEXT: begin
                r_j <= r_j + 1'b1;
            end
            DP_MUL_KEY: begin
                r_key_row <= r_a.row;
                r_key_col <= r_b_q.col;
                r_delta   <= r_a.val * r_b_q.val;
                r_j       <= r_j + 1'b1;
            end
            DP_B_KEY: begin
                r_key_row <= r_b_q.row;
                r_key_col <= r_b_q.col;
                r_delta   <= (t_opcode'(r_in.opcode) == OP_ADD) ? r_b_q.val
                                                                 : ('0 - r_b_q.val);
                r_j       <= r_j + 1'b1;
            end
            DP_ACC_INIT: begin
                r_k     <= '0;
                r_w     <= '0;
                r_cur   <= '0;
                r_found <= 1'b0;
            end
            DP_ACC_STEP: begin
                // The first match supplies the old value; every match is squeezed out.
                if (o_stat.acc_match) begin
                    if (!r_found) begin
                        r_cur   <= r_r_q.val;
                        r_found <= 1'b1;
                    end
                end else begin
                    r_w <= r_w + 1'b1;
                end
                r_k <= r_k + 1'b1;
            end
            DP_EMIT_INIT: begin
                r_k <= '0;
            end
            DP_EMIT_EMPTY: begin
                r_out <= '{out_row: '0, out_col: '0, out_value: '0, entry_valid: 1'b0,
                           status: r_ovf ? ST_OVERFLOW : ST_OK, last: 1'b1};
            end
            DP_EMIT_ITEM: begin
                r_out <= '{out_row: r_r_q.row, out_col: r_r_q.col, out_value: r_r_q.val,
                           entry_valid: 1'b1, status: r_ovf ? ST_OVERFLOW : ST_OK,
                           last: o_stat.emit_last};
                r_k   <= r_k + 1'b1;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    always_comb begin
        o_stat.op        = t_opcode'(r_in.opcode);
        case (t_opcode'(r_in.opcode))
            OP_MUL:       o_stat.dim_ok = (r_a_cols == r_b_rows);
            OP_TRANSPOSE: o_stat.dim_ok = 1'b1;
            default:      o_stat.dim_ok = (r_a_rows == r_b_rows) && (r_a_cols == r_b_cols);
        endcase
        o_stat.i_end     = (r_i == r_a_cnt);
        o_stat.j_end     = (r_j == r_b_cnt);
        o_stat.k_end     = (r_k == r_r_cnt);
        o_stat.r_empty   = (r_r_cnt == '0);
        o_stat.emit_last = ((r_k + 1'b1) == r_r_cnt);
        o_stat.out_free  = out_free;
        o_stat.div_busy  = div_busy;
        o_stat.b_match   = (r_b_q.row == r_a.row) && (r_b_q.col == r_a.col);
        o_stat.mul_match = (r_a.col == r_b_q.row);
        o_stat.acc_match = (r_r_q.row == r_key_row) && (r_r_q.col == r_key_col);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: rtl/smte_ctrl.sv
// ============================================================================
// smte_ctrl: sequencer of the sparse matrix triplet engine
// Walks the stored lists for each command and issues at most one datapath
// operation per cycle by datapath status, waiting on the output or divider.
// ============================================================================
`default_nettype none

module smte_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire smte_pkg::t_dp_stat i_stat,
    output smte_pkg::t_dp_op        o_cmd
);
    import smte_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = DP_ACCEPT;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.op == OP_LOAD_A || i_stat.op == OP_LOAD_B) begin
                    n_state = S_LOAD;
                end else if (i_stat.op == OP_CLEAR) begin
                    n_state = S_CLEAR;
                end else if (!i_stat.dim_ok) begin
                    n_state = S_MISMATCH;
                end else begin
                    o_cmd   = DP_INIT;
                    n_state = S_A_RD;
                end
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd   = DP_LOAD;
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                if (i_stat.out_free) begin
                    o_cmd   = DP_CLEAR;
                    n_state = S_IDLE;
                end
            end
            S_MISMATCH: begin
                if (i_stat.out_free) begin
                    o_cmd   = DP_MISMATCH;
                    n_state = S_IDLE;
                end
            end
            S_A_RD: begin
                if (!i_stat.i_end) begin
                    n_state = S_A_GOT;
                end else if (i_stat.op == OP_ADD || i_stat.op == OP_SUB) begin
                    n_state = S_B_RD;
                end else begin
                    n_state = S_EMIT_INIT;
                end
            end
            S_A_GOT: begin
                o_cmd = DP_A_LATCH;
                case (i_stat.op)
                    OP_MUL:  n_state = S_MB_RD;
                    OP_DIV:  n_state = S_DV_BRD;
                    default: n_state = S_A_APP;
                endcase
            end
            S_A_APP: begin
                o_cmd   = DP_A_APPEND;
                n_state = S_A_RD;
            end
            S_B_RD: begin
                n_state = i_stat.j_end ? S_EMIT_INIT : S_B_GOT;
            end
            S_B_GOT: begin
                o_cmd   = DP_B_KEY;
                n_state = S_ACC_START;
            end
            S_MB_RD: begin
                if (i_stat.j_end) begin
                    o_cmd   = DP_I_NEXT;
                    n_state = S_A_RD;
                end else begin
                    n_state = S_MB_GOT;
                end
            end
            S_MB_GOT: begin
                if (i_stat.mul_match) begin
                    o_cmd   = DP_MUL_KEY;
                    n_state = S_ACC_START;
                end else begin
                    o_cmd   = DP_J_NEXT;
                    n_state = S_MB_RD;
                end
            end
            S_DV_BRD: begin
                if (i_stat.j_end) begin
                    o_cmd   = DP_I_NEXT;
                    n_state = S_A_RD;
                end else begin
                    n_state = S_DV_BGOT;
                end
            end
            S_DV_BGOT: begin
                if (i_stat.b_match) begin
                    o_cmd   = DP_DIV_START;
                    n_state = S_DV_WAIT;
                end else begin
                    o_cmd   = DP_J_NEXT;
                    n_state = S_DV_BRD;
                end
            end
            S_DV_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd   = DP_DIV_APPEND;
                    n_state = S_A_RD;
                end
            end
            S_ACC_START: begin
                o_cmd   = DP_ACC_INIT;
                n_state = S_ACC_RD;
            end
            S_ACC_RD: begin
                n_state = i_stat.k_end ? S_ACC_FIN : S_ACC_GOT;
            end
            S_ACC_GOT: begin
                o_cmd   = DP_ACC_STEP;
                n_state = S_ACC_RD;
            end
            S_ACC_FIN: begin
                o_cmd   = DP_ACC_FIN;
                n_state = (i_stat.op == OP_MUL) ? S_MB_RD : S_B_RD;
            end
            S_EMIT_INIT: begin
                o_cmd   = DP_EMIT_INIT;
                n_state = i_stat.r_empty ? S_EMIT_EMPTY : S_EMIT_RD;
            end
            S_EMIT_EMPTY: begin
                if (i_stat.out_free) begin
                    o_cmd   = DP_EMIT_EMPTY;
                    n_state = S_IDLE;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_GOT;
            end
            S_EMIT_GOT: begin
                if (i_stat.out_free) begin
                    o_cmd   = DP_EMIT_ITEM;
                    n_state = i_stat.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/sparse_matrix_triplet_engine.sv
// ============================================================================
// sparse_matrix_triplet_engine: sparse matrix operations on triplet lists
// Stores matrices A and B as ordered (row, col, value) lists and computes
// add, subtract, multiply, element-wise divide and transpose results.
// ============================================================================
//
//  Channel   Direction  Handshake             Beat
//  in        input      i_in_valid/o_in_stall  one command (t_in)
//  out       output     o_out_valid/i_out_stall one result item (t_out)
//  cfg       input      i_cfg_valid/o_cfg_ready register index and value
//
// A load, clear or mismatch passes through acceptance, dispatch and its own
// state, which sends the status beat once the output register is free.
// Compute commands are carried out by the sequencer walking the lists
// through registered reads: it copies A entries, scans B entries, rescans
// the result list on every accumulation and waits on the divider for each
// quotient. Emit then sends the result items in list order. Reset is
// synchronous and clears the counts; store contents are left as they are.
// A stall on the output holds the sequencer at its next output beat.
`default_nettype none

module sparse_matrix_triplet_engine #(
    parameter int MAX_NNZ = smte_pkg::MAX_NNZ_DEF,
    parameter int MAX_DIM = smte_pkg::MAX_DIM_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire smte_pkg::t_in               i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output smte_pkg::t_out                   o_out_data,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [smte_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [smte_pkg::DIM_W-1:0]  i_cfg_data
);
    import smte_pkg::*;

    t_dp_op   cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    smte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    smte_dp #(
        .MAX_NNZ (MAX_NNZ),
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

`default_nettype wire

// File: sim/tb_sparse_matrix_triplet_engine.sv
// ============================================================================
// tb_sparse_matrix_triplet_engine: self-checking bench for the triplet engine
// Loads matrices A and B through the command channel and checks every result
// beat against an in-bench model of the engine. It covers loads, clear and all
// compute operations under changing dimensions, and varies sender gaps and
// receiver stalls.
// ============================================================================
`default_nettype none

module tb_sparse_matrix_triplet_engine;
    import smte_pkg::*;

    localparam int NNZ         = 32;
    localparam int DIM_CAP     = 256;
    localparam int ITEM_TARGET = 260;
    localparam int IDLE_LIMIT  = 400000;

    // In-bench model of the engine plus the queue of triplets it predicts.
    class matrix_scoreboard;
        t_trip       a_list[NNZ];
        t_trip       b_list[NNZ];
        t_trip       r_list[NNZ];
        int          a_n, b_n, r_n;
        bit          r_ovf;
        logic [8:0]  a_rows, a_cols, b_rows, b_cols;
        t_out        due_items[$];
        int          errors;

        function new();
            a_n = 0; b_n = 0; r_n = 0; r_ovf = 0;
            a_rows = 0; a_cols = 0; b_rows = 0; b_cols = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        function void set_reg(logic [CFG_IW-1:0] idx, logic [DIM_W-1:0] v);
            case (idx)
                REG_A_ROWS: a_rows = v;
                REG_A_COLS: a_cols = v;
                REG_B_ROWS: b_rows = v;
                REG_B_COLS: b_cols = v;
                default: ;
            endcase
        endfunction

        function void push_status(logic [2:0] st);
            t_out o;
            o = '0;
            o.status = st;
            o.last = 1'b1;
            due_items = {due_items, o};
        endfunction

        function int cap(logic [8:0] d);
            return (d > DIM_CAP) ? DIM_CAP : int'(d);
        endfunction

        function logic [2:0] store_triplet(bit to_b, logic [7:0] r, logic [7:0] c,
                                           logic [31:0] v);
            int rows, cols;
            rows = to_b ? cap(b_rows) : cap(a_rows);
            cols = to_b ? cap(b_cols) : cap(a_cols);
            if (int'(r) >= rows || int'(c) >= cols) return ST_REJECT;
            if (v == 0) return ST_ZERO;
            if ((to_b ? b_n : a_n) >= NNZ) return ST_FULL;
            if (to_b) begin
                b_list[b_n] = '{r, c, v};
                b_n++;
            end else begin
                a_list[a_n] = '{r, c, v};
                a_n++;
            end
            return ST_OK;
        endfunction

        function void res_push(logic [7:0] r, logic [7:0] c, logic [31:0] v);
            if (v == 0) return;
            if (r_n >= NNZ) begin
                r_ovf = 1;
                return;
            end
            r_list[r_n] = '{r, c, v};
            r_n++;
        endfunction

        // Drops every result entry at (r, c) and appends the first one's value plus delta.
        function void res_merge(logic [7:0] r, logic [7:0] c, logic [31:0] delta);
            logic [31:0] cur;
            bit          seen;
            int          w;
            cur = 0; seen = 0; w = 0;
            for (int i = 0; i < r_n; i++) begin
                if (r_list[i].row == r && r_list[i].col == c) begin
                    if (!seen) cur = r_list[i].val;
                    seen = 1;
                end else begin
                    r_list[w] = r_list[i];
                    w++;
                end
            end
            r_n = w;
            res_push(r, c, cur + delta);
        endfunction

        function logic [31:0] b_value_at(logic [7:0] r, logic [7:0] c);
            for (int j = 0; j < b_n; j++)
                if (b_list[j].row == r && b_list[j].col == c) return b_list[j].val;
            return 0;
        endfunction

        function logic [31:0] trunc_quotient(logic [31:0] x, logic [31:0] y);
            logic [31:0] ux, uy, q;
            ux = x[31] ? -x : x;
            uy = y[31] ? -y : y;
            q = ux / uy;
            return (x[31] ^ y[31]) ? -q : q;
        endfunction

        function void note_input(t_in x);
            t_out        o;
            logic [31:0] d;
            case (t_opcode'(x.opcode))
                OP_LOAD_A: begin
                    push_status(store_triplet(0, x.row_index, x.col_index, x.entry_value));
                    return;
                end
                OP_LOAD_B: begin
                    push_status(store_triplet(1, x.row_index, x.col_index, x.entry_value));
                    return;
                end
                OP_CLEAR: begin
                    a_n = 0; b_n = 0; r_n = 0; r_ovf = 0;
                    push_status(ST_OK);
                    return;
                end
                OP_MUL: begin
                    if (a_cols != b_rows) begin
                        push_status(ST_MISMATCH);
                        return;
                    end
                end
                OP_TRANSPOSE: ;
                default: begin
                    if (a_rows != b_rows || a_cols != b_cols) begin
                        push_status(ST_MISMATCH);
                        return;
                    end
                end
            endcase
            r_n = 0;
            r_ovf = 0;
            case (t_opcode'(x.opcode))
                OP_ADD, OP_SUB: begin
                    for (int i = 0; i < a_n; i++)
                        res_push(a_list[i].row, a_list[i].col, a_list[i].val);
                    for (int j = 0; j < b_n; j++) begin
                        d = (x.opcode == OP_ADD) ? b_list[j].val : -b_list[j].val;
                        res_merge(b_list[j].row, b_list[j].col, d);
                    end
                end
                OP_MUL: begin
                    for (int i = 0; i < a_n; i++)
                        for (int j = 0; j < b_n; j++)
                            if (a_list[i].col == b_list[j].row)
                                res_merge(a_list[i].row, b_list[j].col,
                                          a_list[i].val * b_list[j].val);
                end
                OP_DIV: begin
                    for (int i = 0; i < a_n; i++) begin
                        d = b_value_at(a_list[i].row, a_list[i].col);
                        if (d != 0)
                            res_push(a_list[i].row, a_list[i].col,
                                     trunc_quotient(a_list[i].val, d));
                    end
                end
                default: begin
                    for (int i = 0; i < a_n; i++)
                        res_push(a_list[i].col, a_list[i].row, a_list[i].val);
                end
            endcase
            if (r_n == 0) begin
                push_status(r_ovf ? ST_OVERFLOW : ST_OK);
                return;
            end
            for (int i = 0; i < r_n; i++) begin
                o.out_row = r_list[i].row;
                o.out_col = r_list[i].col;
                o.out_value = r_list[i].val;
                o.entry_valid = 1'b1;
                o.status = r_ovf ? ST_OVERFLOW : ST_OK;
                o.last = (i == r_n - 1);
                due_items = {due_items, o};
            end
        endfunction

        task check_result(t_out got);
            t_out want;
            if (due_items.size() == 0) begin
                report($sformatf("unexpected result beat %h", got));
                return;
            end
            want = due_items.pop_front();
            if (got.out_row !== want.out_row)
                report($sformatf("out_row %0d, want %0d", got.out_row, want.out_row));
            if (got.out_col !== want.out_col)
                report($sformatf("out_col %0d, want %0d", got.out_col, want.out_col));
            if (got.out_value !== want.out_value)
                report($sformatf("out_value %h, want %h", got.out_value, want.out_value));
            if (got.entry_valid !== want.entry_valid)
                report($sformatf("entry_valid %b, want %b", got.entry_valid,
                                 want.entry_valid));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.last !== want.last)
                report($sformatf("last %b, want %b", got.last, want.last));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in                 i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out                o_out_data;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_IW-1:0]   i_cfg_index;
    logic [DIM_W-1:0]    i_cfg_data;

    matrix_scoreboard    sb;
    int                  sent_count;
    int                  idle_pct;
    int                  stall_pct;
    int                  quiet_cycles;

    sparse_matrix_triplet_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    // Ends the run when no channel has moved a beat for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_sparse_matrix_triplet_engine NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task send_cmd(t_opcode op, logic [7:0] r, logic [7:0] c, logic [31:0] v);
        t_in item;
        int  gap;
        item.opcode = op;
        item.row_index = r;
        item.col_index = c;
        item.entry_value = v;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(item);
        sent_count++;
    endtask

    task wait_results_done();
        i_in_valid <= 1'b0;
        while (sb.due_items.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Leaves the write channel valid; the caller drops it after the last write.
    task write_reg(logic [CFG_IW-1:0] idx, logic [DIM_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, v);
    endtask

    task set_dims(logic [8:0] ar, logic [8:0] ac, logic [8:0] br, logic [8:0] bc);
        wait_results_done();
        write_reg(REG_A_ROWS, ar);
        write_reg(REG_A_COLS, ac);
        write_reg(REG_B_ROWS, br);
        write_reg(REG_B_COLS, bc);
        i_cfg_valid <= 1'b0;
    endtask

    function logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 0;
            1, 2:    return $urandom;
            3:       return {1'b1, 31'd0} + $urandom_range(3);
            default: return $urandom_range(14) - 7;
        endcase
    endfunction

    // One load-and-compute sequence on the current dimensions.
    task run_sequence(int dim, bit big);
        int      n;
        t_opcode op;
        send_cmd(OP_CLEAR, 8'($urandom), 8'($urandom), $urandom);
        for (int m = 0; m < 2; m++) begin
            n = big ? $urandom_range(28, 36) : $urandom_range(0, 8);
            for (int k = 0; k < n; k++) begin
                op = m ? OP_LOAD_B : OP_LOAD_A;
                if ($urandom_range(19) == 0)
                    send_cmd(op, 8'($urandom), 8'($urandom), pick_value());
                else
                    send_cmd(op, 8'($urandom_range(dim - 1)), 8'($urandom_range(dim - 1)),
                             pick_value());
            end
        end
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(9) == 0)
                send_cmd(t_opcode'($urandom_range(7)), 8'($urandom), 8'($urandom),
                         $urandom);
            else
                send_cmd(t_opcode'($urandom_range(OP_ADD, OP_TRANSPOSE)),
                         8'($urandom), 8'($urandom), $urandom);
        end
    endtask

    initial begin
        int dim;
        int target;
        sb = new();
        sent_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes of indices and values, wraparound, cancellation,
        // divide by minus one, mismatches, an empty result and rejected indices.
        set_dims(9'd256, 9'd256, 9'd256, 9'd256);
        send_cmd(OP_LOAD_A, 8'd255, 8'd255, 32'h7fffffff);
        send_cmd(OP_LOAD_A, 8'd0, 8'd0, 32'h80000000);
        send_cmd(OP_LOAD_A, 8'd0, 8'd1, 32'd5);
        send_cmd(OP_LOAD_A, 8'd1, 8'd1, 32'd0);
        send_cmd(OP_LOAD_B, 8'd0, 8'd0, 32'hffffffff);
        send_cmd(OP_LOAD_B, 8'd255, 8'd255, 32'd1);
        send_cmd(OP_LOAD_B, 8'd0, 8'd1, -32'sd5);
        send_cmd(OP_ADD, 8'd0, 8'd0, 32'd0);
        send_cmd(OP_SUB, 8'd0, 8'd0, 32'd0);
        send_cmd(OP_DIV, 8'd0, 8'd0, 32'd0);
        send_cmd(OP_TRANSPOSE, 8'd0, 8'd0, 32'd0);
        send_cmd(OP_MUL, 8'd0, 8'd0, 32'd0);
        set_dims(9'd4, 9'd255, 9'd255, 9'd0);
        send_cmd(OP_ADD, 8'd0, 8'd0, 32'd0);
        send_cmd(OP_MUL, 8'd0, 8'd0, 32'd0);
        send_cmd(OP_DIV, 8'd0, 8'd0, 32'd0);
        send_cmd(OP_LOAD_A, 8'd200, 8'd0, 32'd3);
        send_cmd(OP_LOAD_A, 8'd0, 8'd255, 32'd3);
        send_cmd(OP_LOAD_B, 8'd0, 8'd0, 32'd3);
        send_cmd(OP_CLEAR, 8'd0, 8'd0, 32'd0);
        send_cmd(OP_TRANSPOSE, 8'd0, 8'd0, 32'd0);

        // Random phases: the idling mode rotates, dimensions change between phases.
        target = ITEM_TARGET;
        for (int p = 0; sent_count < target; p++) begin
            wait_results_done();
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 68; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 68; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            case (p % 6)
                1: dim = 1;
                3: dim = 256;
                4: dim = 8;
                default: dim = $urandom_range(2, 4);
            endcase
            if (p == 2)
                set_dims(9'd0, 9'd0, 9'd0, 9'd0);
            else if ($urandom_range(4) == 0)
                set_dims(9'(dim), 9'(dim), 9'(dim), 9'(dim + 1));
            else
                set_dims(9'(dim), 9'(dim), 9'(dim), 9'(dim));
            run_sequence(dim, dim == 8);
            if (p == 5) wait_results_done();
            run_sequence(dim, 1'b0);
        end

        wait_results_done();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.due_items.size() == 0) begin
            $display("tb_sparse_matrix_triplet_engine OK");
        end else begin
            $display("tb_sparse_matrix_triplet_engine NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
